/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* sv/aslog_pkg.sv */
package aslog_pkg;

    localparam int ADDR_W = 24;
    localparam int DVD_W  = 32;
    localparam int DSR_W  = 8;

    // input selector (tuser)
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // flash command codes
    localparam logic [1:0] CMD_WRITE_RECORD = 2'd0;
    localparam logic [1:0] CMD_WRITE_CLOSED = 2'd1;
    localparam logic [1:0] CMD_ERASE_SECTOR = 2'd2;
    localparam logic [1:0] CMD_WRITE_TAG    = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_AVERAGE_COUNT = 2'd0;
    localparam logic [1:0] REG_REGION_START  = 2'd1;
    localparam logic [1:0] REG_REGION_END    = 2'd2;
    localparam logic [1:0] REG_SECTOR_TAG    = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] flash_address;
        logic [31:0]       data_word;
        logic [31:0]       record_time;
        logic [15:0]       record_temperature;
        logic [15:0]       record_humidity;
        logic [15:0]       record_battery;
        logic              last;
    } out_beat_t;

endpackage

/* sv/aslog_div.sv */
`include "assert_macros.svh"

module aslog_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  aslog_pkg::div_req_t          req,
    output logic                         done,
    output logic [aslog_pkg::DVD_W-1:0]  quotient
);
    import aslog_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W-1:0] rem_reg, rem_next;

    logic [DSR_W:0]   rem_shift;
    logic [DSR_W+1:0] diff;
    logic             geq;

    // restoring divide, one quotient bit per cycle; quotient shifts into dvd_reg
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};
    assign geq       = !diff[DSR_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], geq};
            rem_next = geq ? diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

    `ASSERT_IMPLIES(a_div_start_idle, aclk, aresetn, req.start, !busy_reg)
    `ASSERT_NEXT(a_div_done_after_last, aclk, aresetn, busy_reg && (cnt_reg == '0), done_reg)
    `ASSERT_IMPLIES(a_div_nonzero_divisor, aclk, aresetn, req.start, req.divisor != '0)

endmodule

/* sv/averaging_sector_ring_logger.sv */
// Flow: the first beat is loaded into the output register from the state entered
//   on the accepting edge, once the output is free; a sample that closes an averaging
//   window first runs three divides on one shared serial divider.
// Input: s_tready is high only in idle; a sample that only sums leaves the block
//   idle, any other sample or restart holds s_tready low until its beats are loaded.
// Reset: synchronous, active low; clears control and log state, configuration to defaults.
`include "assert_macros.svh"

module averaging_sector_ring_logger #(
    parameter int SECTOR_BYTES = 4096,
    parameter int HEADER_BYTES = 4,
    parameter int RECORD_BYTES = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,  // temperature, humidity, battery, timestamp
    input  logic         s_tuser,  // opcode
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // flash_address, data_word, record_time, record_temperature,
    // record_humidity, record_battery
    output logic [135:0] m_tdata,
    output logic [1:0]   m_tuser,  // command
    output logic         m_tlast,  // last
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import aslog_pkg::*;

    localparam int RECS_PER_SECTOR = (SECTOR_BYTES - HEADER_BYTES) / RECORD_BYTES;
    localparam logic [ADDR_W-1:0] SEC_MASK = ~ADDR_W'(SECTOR_BYTES - 1);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DIV_GO     = 3'd1;
    localparam logic [2:0] S_DIV_WAIT   = 3'd2;
    localparam logic [2:0] S_OPEN_ERASE = 3'd3;
    localparam logic [2:0] S_OPEN_TAG   = 3'd4;
    localparam logic [2:0] S_RECORD     = 3'd5;
    localparam logic [2:0] S_CLOSE      = 3'd6;

    localparam logic [1:0] SEL_TEMP = 2'd0;
    localparam logic [1:0] SEL_HUM  = 2'd1;
    localparam logic [1:0] SEL_BAT  = 2'd2;

    // configuration registers
    logic [7:0]        avg_count_reg;
    logic [ADDR_W-1:0] region_start_reg;
    logic [ADDR_W-1:0] region_end_reg;
    logic [31:0]       sector_tag_reg;

    // control and log state
    logic [2:0]        state_reg, state_next;
    logic [31:0]       temp_sum_reg, temp_sum_next;
    logic [31:0]       hum_sum_reg, hum_sum_next;
    logic [31:0]       bat_sum_reg, bat_sum_next;
    logic [7:0]        sample_count_reg, sample_count_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    logic [11:0]       rec_cnt_reg, rec_cnt_next;
    logic [ADDR_W-1:0] open_addr_reg, open_addr_next;
    logic              rec_after_open_reg, rec_after_open_next;
    logic [1:0]        div_sel_reg, div_sel_next;
    logic              temp_neg_reg, temp_neg_next;
    logic              m_tvalid_reg;

    // payload
    logic [31:0]       ts_reg, ts_next;
    logic [15:0]       t_rec_reg, t_rec_next;
    logic [15:0]       h_rec_reg, h_rec_next;
    logic [15:0]       b_rec_reg, b_rec_next;
    out_beat_t         out_reg;

    // datapath
    logic [15:0]       in_temp, in_hum, in_bat;
    logic [31:0]       in_ts;
    logic [7:0]        cnt_inc;
    logic              out_free, out_load;
    out_beat_t         out_beat;
    div_req_t          div_req;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;
    logic [ADDR_W-1:0] open_base, cur_base, nxt_rec_base, nxt_sector;
    logic [ADDR_W:0]   sector_sum;
    logic [12:0]       rec_cnt_p1;
    logic              sector_full;
    logic              cfg_wr;
    logic              div_phase;

    assign in_temp = s_tdata[15:0];
    assign in_hum  = s_tdata[31:16];
    assign in_bat  = s_tdata[47:32];
    assign in_ts   = s_tdata[79:48];

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_inc  = sample_count_reg + 8'd1;

    // sector geometry
    assign open_base    = open_addr_reg & SEC_MASK;
    assign cur_base     = wa_reg & SEC_MASK;
    assign nxt_rec_base = (wa_reg + ADDR_W'(RECORD_BYTES)) & SEC_MASK;
    assign rec_cnt_p1   = {1'b0, rec_cnt_reg} + 13'd1;
    assign sector_full  = (rec_cnt_p1 >= 13'(RECS_PER_SECTOR)) || (nxt_rec_base != cur_base);
    assign sector_sum   = {1'b0, cur_base} + (ADDR_W + 1)'(SECTOR_BYTES);

    always_comb begin
        if (sector_sum >= {1'b0, region_end_reg}) begin
            nxt_sector = region_start_reg;
        end else if (sector_sum < {1'b0, region_start_reg}) begin
            nxt_sector = region_end_reg - ADDR_W'(SECTOR_BYTES);
        end else begin
            nxt_sector = sector_sum[ADDR_W-1:0];
        end
    end

    aslog_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next          = state_reg;
        temp_sum_next       = temp_sum_reg;
        hum_sum_next        = hum_sum_reg;
        bat_sum_next        = bat_sum_reg;
        sample_count_next   = sample_count_reg;
        wa_next             = wa_reg;
        rec_cnt_next        = rec_cnt_reg;
        open_addr_next      = open_addr_reg;
        rec_after_open_next = rec_after_open_reg;
        div_sel_next        = div_sel_reg;
        temp_neg_next       = temp_neg_reg;
        ts_next             = ts_reg;
        t_rec_next          = t_rec_reg;
        h_rec_next          = h_rec_reg;
        b_rec_next          = b_rec_reg;
        out_load            = 1'b0;
        out_beat            = '0;
        div_req             = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ts_next = in_ts;
                    if (s_tuser == OP_RESTART) begin
                        open_addr_next      = region_start_reg;
                        rec_after_open_next = 1'b0;
                        state_next          = S_OPEN_ERASE;
                    end else if (avg_count_reg <= 8'd1) begin
                        t_rec_next          = in_temp;
                        h_rec_next          = in_hum;
                        b_rec_next          = in_bat;
                        rec_after_open_next = 1'b1;
                        open_addr_next      = region_start_reg;
                        // log not started: open the first sector before the record
                        state_next = (wa_reg == '0) ? S_OPEN_ERASE : S_RECORD;
                    end else begin
                        temp_sum_next     = temp_sum_reg + {{16{in_temp[15]}}, in_temp};
                        hum_sum_next      = hum_sum_reg + {16'd0, in_hum};
                        bat_sum_next      = bat_sum_reg + {16'd0, in_bat};
                        sample_count_next = cnt_inc;
                        if ((cnt_inc != 8'd0) && (avg_count_reg <= cnt_inc)) begin
                            div_sel_next = SEL_TEMP;
                            state_next   = S_DIV_GO;
                        end
                    end
                end
            end
            S_DIV_GO: begin
                div_req.start   = 1'b1;
                div_req.divisor = sample_count_reg;
                case (div_sel_reg)
                    SEL_TEMP: begin
                        // signed truncating divide as magnitude divide plus sign fix
                        temp_neg_next    = temp_sum_reg[31];
                        div_req.dividend = temp_sum_reg[31] ? (32'd0 - temp_sum_reg)
                                                            : temp_sum_reg;
                    end
                    SEL_HUM:  div_req.dividend = hum_sum_reg;
                    default:  div_req.dividend = bat_sum_reg;
                endcase
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    case (div_sel_reg)
                        SEL_TEMP: t_rec_next = temp_neg_reg ? (16'd0 - div_q[15:0])
                                                            : div_q[15:0];
                        SEL_HUM:  h_rec_next = div_q[15:0];
                        default:  b_rec_next = div_q[15:0];
                    endcase
                    if (div_sel_reg == SEL_BAT) begin
                        temp_sum_next       = '0;
                        hum_sum_next        = '0;
                        bat_sum_next        = '0;
                        sample_count_next   = '0;
                        rec_after_open_next = 1'b1;
                        open_addr_next      = region_start_reg;
                        state_next = (wa_reg == '0) ? S_OPEN_ERASE : S_RECORD;
                    end else begin
                        div_sel_next = div_sel_reg + 2'd1;
                        state_next   = S_DIV_GO;
                    end
                end
            end
            S_OPEN_ERASE: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    out_beat.command       = CMD_ERASE_SECTOR;
                    out_beat.flash_address = open_base;
                    wa_next                = open_base + ADDR_W'(HEADER_BYTES);
                    rec_cnt_next           = '0;
                    state_next             = S_OPEN_TAG;
                end
            end
            S_OPEN_TAG: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    out_beat.command       = CMD_WRITE_TAG;
                    out_beat.flash_address = open_base;
                    out_beat.data_word     = sector_tag_reg;
                    out_beat.last          = !rec_after_open_reg;
                    state_next             = rec_after_open_reg ? S_RECORD : S_IDLE;
                end
            end
            S_RECORD: begin
                if (out_free) begin
                    out_load                    = 1'b1;
                    out_beat.command            = CMD_WRITE_RECORD;
                    out_beat.flash_address      = wa_reg;
                    out_beat.record_time        = ts_reg;
                    out_beat.record_temperature = t_rec_reg;
                    out_beat.record_humidity    = h_rec_reg;
                    out_beat.record_battery     = b_rec_reg;
                    out_beat.last               = !sector_full;
                    if (sector_full) begin
                        state_next = S_CLOSE;
                    end else begin
                        rec_cnt_next = rec_cnt_p1[11:0];
                        wa_next      = wa_reg + ADDR_W'(RECORD_BYTES);
                        state_next   = S_IDLE;
                    end
                end
            end
            S_CLOSE: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    out_beat.command       = CMD_WRITE_CLOSED;
                    out_beat.flash_address = cur_base + ADDR_W'(HEADER_BYTES - 2);
                    open_addr_next         = nxt_sector;
                    rec_after_open_next    = 1'b0;
                    state_next             = S_OPEN_ERASE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            temp_sum_reg       <= '0;
            hum_sum_reg        <= '0;
            bat_sum_reg        <= '0;
            sample_count_reg   <= '0;
            wa_reg             <= '0;
            rec_cnt_reg        <= '0;
            open_addr_reg      <= '0;
            rec_after_open_reg <= 1'b0;
            div_sel_reg        <= SEL_TEMP;
            temp_neg_reg       <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg          <= state_next;
            temp_sum_reg       <= temp_sum_next;
            hum_sum_reg        <= hum_sum_next;
            bat_sum_reg        <= bat_sum_next;
            sample_count_reg   <= sample_count_next;
            wa_reg             <= wa_next;
            rec_cnt_reg        <= rec_cnt_next;
            open_addr_reg      <= open_addr_next;
            rec_after_open_reg <= rec_after_open_next;
            div_sel_reg        <= div_sel_next;
            temp_neg_reg       <= temp_neg_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        ts_reg    <= ts_next;
        t_rec_reg <= t_rec_next;
        h_rec_reg <= h_rec_next;
        b_rec_reg <= b_rec_next;
        if (out_load) begin
            out_reg <= out_beat;
        end
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_count_reg    <= 8'd1;
            region_start_reg <= '0;
            region_end_reg   <= ADDR_W'(311296);
            sector_tag_reg   <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_AVERAGE_COUNT: avg_count_reg    <= pwdata[7:0];
                REG_REGION_START:  region_start_reg <= pwdata[ADDR_W-1:0];
                REG_REGION_END:    region_end_reg   <= pwdata[ADDR_W-1:0];
                REG_SECTOR_TAG:    sector_tag_reg   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_AVERAGE_COUNT: prdata = {24'd0, avg_count_reg};
            REG_REGION_START:  prdata = {8'd0, region_start_reg};
            REG_REGION_END:    prdata = {8'd0, region_end_reg};
            REG_SECTOR_TAG:    prdata = sector_tag_reg;
            default:           prdata = '0;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.command;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.record_battery, out_reg.record_humidity,
                       out_reg.record_temperature, out_reg.record_time,
                       out_reg.data_word, out_reg.flash_address};

    assign div_phase = (state_reg == S_DIV_GO) || (state_reg == S_DIV_WAIT);

    `ASSERT_IMPLIES(a_load_only_free, aclk, aresetn, out_load, out_free)
    `ASSERT_IMPLIES(a_div_count_set, aclk, aresetn, div_phase, sample_count_reg >= 8'd2)
    `ASSERT_IMPLIES(a_record_log_open, aclk, aresetn, state_reg == S_RECORD, wa_reg != '0)
    `ASSERT_IMPLIES(a_no_div_start_late, aclk, aresetn, div_req.start, state_reg == S_DIV_GO)

endmodule
